// File: sv/sdz_pkg.sv
// ----------------------------------------------------------------------------
// sdz_pkg
// Shared types and constants for the stick dead-zone and curve shaper.
// ----------------------------------------------------------------------------
package sdz_pkg;

	localparam logic [16:0] Q16_ONE      = 17'h10000;
	localparam logic [15:0] LINEAR_CURVE = 16'd256;
	localparam logic [15:0] POS_LIMIT    = 16'd32767;
	localparam logic [15:0] NEG_LIMIT    = 16'd32768;
	localparam logic [15:0] FULL_RESET   = 16'd32767;

	localparam logic [2:0] REG_X_CENTER    = 3'd0;
	localparam logic [2:0] REG_Y_CENTER    = 3'd1;
	localparam logic [2:0] REG_DEAD_RADIUS = 3'd2;
	localparam logic [2:0] REG_FULL_RADIUS = 3'd3;
	localparam logic [2:0] REG_CURVE_SHAPE = 3'd4;
	localparam logic [2:0] REG_FLIP_X      = 3'd5;
	localparam logic [2:0] REG_FLIP_Y      = 3'd6;

	// normalise divider: (off << 16 + range / 2) / range
	localparam int U_NUM_W = 33;
	localparam int U_DEN_W = 16;
	localparam int U_Q_W   = 17;
	// curve divider: (u << 24 + den / 2) / den
	localparam int C_NUM_W = 42;
	localparam int C_DEN_W = 33;
	localparam int C_Q_W   = 17;
	// axis scaling divider: (|a| * lim * r + m << 15) / (m << 16)
	localparam int S_NUM_W = 48;
	localparam int S_DEN_W = 32;
	localparam int S_Q_W   = 16;

	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_FULL,
		CLS_BAND
	} cls_t;

	typedef struct packed {
		logic signed [15:0] x_center;
		logic signed [15:0] y_center;
		logic [15:0]        dead_radius;
		logic [15:0]        full_radius;
		logic [15:0]        curve_shape;
		logic               flip_x;
		logic               flip_y;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic [15:0]        m;
		cls_t               cls;
		logic               dflt;
	} band_t;

	typedef struct packed {
		band_t       b;
		logic [16:0] u;
		logic        spec;
	} curve_t;

	typedef struct packed {
		logic               neg;
		logic signed [15:0] a;
	} axis_t;

	typedef struct packed {
		logic  dflt;
		axis_t ax;
	} xside_t;

endpackage

// File: sv/sdz_div_pipe.sv
// ----------------------------------------------------------------------------
// sdz_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module sdz_div_pipe #(
	parameter int NUM_W  = 33,
	parameter int DEN_W  = 16,
	parameter int Q_W    = 17,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [Q_W-1:0]    quot,
	output logic [SIDE_W-1:0] side_out
);

	localparam int CW = (NUM_W > DEN_W + Q_W - 1) ? NUM_W : DEN_W + Q_W - 1;

	logic [CW-1:0]     rem_s  [Q_W-1];
	logic [DEN_W-1:0]  den_s  [Q_W-1];
	logic [Q_W-1:0]    q_s    [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];
	logic              vld_s  [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_st
		localparam int SH = Q_W - 1 - j;
		logic [CW-1:0]     r_in;
		logic [CW-1:0]     sh;
		logic [DEN_W-1:0]  d_in;
		logic [Q_W-1:0]    q_in;
		logic [SIDE_W-1:0] s_in;
		logic              v_in;
		logic              ge;

		if (j == 0) begin : g_in
			assign r_in = CW'(num);
			assign d_in = den;
			assign q_in = '0;
			assign s_in = side_in;
			assign v_in = in_vld;
		end else begin : g_mid
			assign r_in = rem_s[j-1];
			assign d_in = den_s[j-1];
			assign q_in = q_s[j-1];
			assign s_in = side_s[j-1];
			assign v_in = vld_s[j-1];
		end

		assign sh = CW'(d_in) << SH;
		assign ge = (r_in >= sh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[j]    <= q_in | (Q_W'(ge) << SH);
				side_s[j] <= s_in;
			end
		end

		if (j < Q_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= ge ? (r_in - sh) : r_in;
					den_s[j] <= d_in;
				end
			end
		end
	end

	assign out_vld  = vld_s[Q_W-1];
	assign quot     = q_s[Q_W-1];
	assign side_out = side_s[Q_W-1];

endmodule

// File: sv/sdz_front.sv
// ----------------------------------------------------------------------------
// sdz_front
// Centre offset and clamp, magnitude, dead/full band classification and
// numerator set-up for the normalising divider.
// ----------------------------------------------------------------------------
module sdz_front
	import sdz_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  cfg_t                cfg,
	input  logic                in_vld,
	input  logic signed [15:0]  x_raw,
	input  logic signed [15:0]  y_raw,
	output logic                out_vld,
	output logic [U_NUM_W-1:0]  num,
	output logic [U_DEN_W-1:0]  den,
	output band_t               side
);

	logic signed [16:0] dx, dy;
	logic signed [15:0] cx, cy;
	logic               dflt;

	logic signed [15:0] ax_s1, ay_s1;
	logic               dflt_s1, vld_s1;

	logic [15:0] mx, my, mm;
	cls_t        cls;

	band_t       side_s2;
	logic [15:0] off_s2, range_s2;
	logic        vld_s2;

	band_t               side_s3;
	logic [U_NUM_W-1:0]  num_s3;
	logic [U_DEN_W-1:0]  den_s3;
	logic                vld_s3;

	function automatic logic signed [15:0] sat16(input logic signed [16:0] d);
		logic signed [15:0] r;
		if (d > 17'sd32767) begin
			r = 16'sh7fff;
		end else if (d < -17'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = d[15:0];
		end
		return r;
	endfunction

	always_comb begin
		dx   = 17'(x_raw) - 17'(cfg.x_center);
		dy   = 17'(y_raw) - 17'(cfg.y_center);
		cx   = sat16(dx);
		cy   = sat16(dy);
		dflt = (cfg.x_center == '0) && (cfg.y_center == '0) && (cfg.dead_radius == '0) &&
			(cfg.full_radius == FULL_RESET) && (cfg.curve_shape == LINEAR_CURVE) &&
			!cfg.flip_x && !cfg.flip_y;
	end

	always_comb begin
		mx = ax_s1[15] ? 16'(-ax_s1) : 16'(ax_s1);
		my = ay_s1[15] ? 16'(-ay_s1) : 16'(ay_s1);
		mm = (mx > my) ? mx : my;
		if (mm <= cfg.dead_radius) begin
			cls = CLS_ZERO;
		end else if (mm >= cfg.full_radius) begin
			cls = CLS_FULL;
		end else begin
			cls = CLS_BAND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1        <= cx;
			ay_s1        <= cy;
			dflt_s1      <= dflt;
			side_s2.ax   <= ax_s1;
			side_s2.ay   <= ay_s1;
			side_s2.m    <= mm;
			side_s2.cls  <= cls;
			side_s2.dflt <= dflt_s1;
			off_s2       <= mm - cfg.dead_radius;
			range_s2     <= cfg.full_radius - cfg.dead_radius;
			side_s3      <= side_s2;
			num_s3       <= {1'b0, off_s2, 16'b0} + U_NUM_W'(range_s2 >> 1);
			den_s3       <= range_s2;
		end
	end

	assign out_vld = vld_s3;
	assign num     = num_s3;
	assign den     = den_s3;
	assign side    = side_s3;

endmodule

// File: sv/sdz_curve.sv
// ----------------------------------------------------------------------------
// sdz_curve
// Rational response curve set-up: denominator c*(1-u) + u and rounded
// numerator for the curve divider.
// ----------------------------------------------------------------------------
module sdz_curve
	import sdz_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [15:0]         curve_shape,
	input  logic                in_vld,
	input  logic [U_Q_W-1:0]    u_in,
	input  band_t               side_in,
	output logic                out_vld,
	output logic [C_NUM_W-1:0]  num,
	output logic [C_DEN_W-1:0]  den,
	output curve_t              side_out
);

	logic [16:0] diff;

	curve_t              side_s1, side_s2, side_s3;
	logic [C_DEN_W-1:0]  prod_s1, den_s2, den_s3;
	logic [C_NUM_W-1:0]  num_s3;
	logic                vld_s1, vld_s2, vld_s3;

	assign diff = Q16_ONE - u_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.b    <= side_in;
			side_s1.u    <= u_in;
			side_s1.spec <= (u_in == '0) || (u_in == Q16_ONE) || (curve_shape == LINEAR_CURVE);
			prod_s1      <= C_DEN_W'(curve_shape) * C_DEN_W'(diff);
			side_s2      <= side_s1;
			den_s2       <= prod_s1 + (C_DEN_W'(side_s1.u) << 8);
			side_s3      <= side_s2;
			den_s3       <= den_s2;
			num_s3       <= (C_NUM_W'(side_s2.u) << 24) + C_NUM_W'(den_s2 >> 1);
		end
	end

	assign out_vld  = vld_s3;
	assign num      = num_s3;
	assign den      = den_s3;
	assign side_out = side_s3;

endmodule

// File: sv/sdz_scale.sv
// ----------------------------------------------------------------------------
// sdz_scale
// Response select, per-axis products and the two axis scaling dividers.
// ----------------------------------------------------------------------------
module sdz_scale
	import sdz_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               flip_x,
	input  logic               flip_y,
	input  logic               in_vld,
	input  logic [C_Q_W-1:0]   q_in,
	input  curve_t             side_in,
	output logic               out_vld,
	output logic [S_Q_W-1:0]   x_quot,
	output logic [S_Q_W-1:0]   y_quot,
	output xside_t             x_side,
	output axis_t              y_side
);

	logic [16:0] r;
	logic [15:0] magx, magy, limx, limy;
	logic        negx, negy;

	logic [16:0]  r_s1;
	logic [30:0]  px_s1, py_s1;
	logic [15:0]  m_s1, m_s2;
	xside_t       xs_s1, xs_s2, xs_s3;
	axis_t        ys_s1, ys_s2, ys_s3;
	logic [46:0]  px_s2, py_s2;
	logic [S_NUM_W-1:0] nx_s3, ny_s3;
	logic [S_DEN_W-1:0] d_s3;
	logic         vld_s1, vld_s2, vld_s3;
	logic         vx, vy;

	always_comb begin
		case (side_in.b.cls)
			CLS_ZERO: r = '0;
			CLS_FULL: r = Q16_ONE;
			CLS_BAND: r = side_in.spec ? side_in.u : q_in;
			default:  r = '0;
		endcase
		negx = side_in.b.ax[15] ^ flip_x;
		negy = side_in.b.ay[15] ^ flip_y;
		limx = negx ? NEG_LIMIT : POS_LIMIT;
		limy = negy ? NEG_LIMIT : POS_LIMIT;
		magx = side_in.b.ax[15] ? 16'(-side_in.b.ax) : 16'(side_in.b.ax);
		magy = side_in.b.ay[15] ? 16'(-side_in.b.ay) : 16'(side_in.b.ay);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1        <= r;
			px_s1       <= 31'(magx) * 31'(limx);
			py_s1       <= 31'(magy) * 31'(limy);
			m_s1        <= side_in.b.m;
			xs_s1.dflt  <= side_in.b.dflt;
			xs_s1.ax.neg <= negx;
			xs_s1.ax.a  <= side_in.b.ax;
			ys_s1.neg   <= negy;
			ys_s1.a     <= side_in.b.ay;
			px_s2       <= 47'(px_s1) * 47'(r_s1);
			py_s2       <= 47'(py_s1) * 47'(r_s1);
			m_s2        <= m_s1;
			xs_s2       <= xs_s1;
			ys_s2       <= ys_s1;
			nx_s3       <= S_NUM_W'(px_s2) + (S_NUM_W'(m_s2) << 15);
			ny_s3       <= S_NUM_W'(py_s2) + (S_NUM_W'(m_s2) << 15);
			d_s3        <= {((m_s2 == '0) ? 16'd1 : m_s2), 16'b0};
			xs_s3       <= xs_s2;
			ys_s3       <= ys_s2;
		end
	end

	sdz_div_pipe #(
		.NUM_W  (S_NUM_W),
		.DEN_W  (S_DEN_W),
		.Q_W    (S_Q_W),
		.SIDE_W ($bits(xside_t))
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.num      (nx_s3),
		.den      (d_s3),
		.side_in  (xs_s3),
		.out_vld  (vx),
		.quot     (x_quot),
		.side_out (x_side)
	);

	sdz_div_pipe #(
		.NUM_W  (S_NUM_W),
		.DEN_W  (S_DEN_W),
		.Q_W    (S_Q_W),
		.SIDE_W ($bits(axis_t))
	) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.num      (ny_s3),
		.den      (d_s3),
		.side_in  (ys_s3),
		.out_vld  (vy),
		.quot     (y_quot),
		.side_out (y_side)
	);

	assign out_vld = vx & vy;

endmodule

// File: sv/stick_deadzone_curve_shaper_core.sv
// ----------------------------------------------------------------------------
// stick_deadzone_curve_shaper_core
// Stick dead-zone and response curve shaper: centre, clamp, dead/full band,
// rational curve, per-axis rescale with saturation and optional flip.
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle while the skid stage is empty, set by
// the bit-per-stage dividers
// a two-entry output register and skid stage keep input open while a result
// waits; the whole pipeline holds only when the skid stage is occupied
// reset clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module stick_deadzone_curve_shaper_core
	import sdz_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] x_raw,
	input  logic signed [15:0] y_raw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] x_shaped,
	output logic signed [15:0] y_shaped,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata
);

	cfg_t cfg_q;
	logic en;

	logic               f_vld;
	logic [U_NUM_W-1:0] f_num;
	logic [U_DEN_W-1:0] f_den;
	band_t              f_side;

	logic               u_vld;
	logic [U_Q_W-1:0]   u_q;
	band_t              u_side;

	logic               c_vld;
	logic [C_NUM_W-1:0] c_num;
	logic [C_DEN_W-1:0] c_den;
	curve_t             c_side;

	logic               r_vld;
	logic [C_Q_W-1:0]   r_q;
	curve_t             r_side;

	logic               s_vld;
	logic [S_Q_W-1:0]   sx_q, sy_q;
	xside_t             sx_side;
	axis_t              sy_side;

	logic signed [15:0] x_fin, y_fin;

	logic               out_vld_q, skid_vld_q;
	logic signed [15:0] x_out_q, y_out_q, x_skid_q, y_skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{x_center: '0, y_center: '0, dead_radius: '0,
				full_radius: FULL_RESET, curve_shape: LINEAR_CURVE,
				flip_x: 1'b0, flip_y: 1'b0};
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_X_CENTER:    cfg_q.x_center    <= cfg_wdata;
				REG_Y_CENTER:    cfg_q.y_center    <= cfg_wdata;
				REG_DEAD_RADIUS: cfg_q.dead_radius <= cfg_wdata;
				REG_FULL_RADIUS: cfg_q.full_radius <= cfg_wdata;
				REG_CURVE_SHAPE: cfg_q.curve_shape <= cfg_wdata;
				REG_FLIP_X:      cfg_q.flip_x      <= cfg_wdata[0];
				REG_FLIP_Y:      cfg_q.flip_y      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign en       = !skid_vld_q;
	assign in_ready = en;

	sdz_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.cfg     (cfg_q),
		.in_vld  (in_valid),
		.x_raw   (x_raw),
		.y_raw   (y_raw),
		.out_vld (f_vld),
		.num     (f_num),
		.den     (f_den),
		.side    (f_side)
	);

	sdz_div_pipe #(
		.NUM_W  (U_NUM_W),
		.DEN_W  (U_DEN_W),
		.Q_W    (U_Q_W),
		.SIDE_W ($bits(band_t))
	) u_div_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (f_vld),
		.num      (f_num),
		.den      (f_den),
		.side_in  (f_side),
		.out_vld  (u_vld),
		.quot     (u_q),
		.side_out (u_side)
	);

	sdz_curve u_curve (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.curve_shape (cfg_q.curve_shape),
		.in_vld      (u_vld),
		.u_in        (u_q),
		.side_in     (u_side),
		.out_vld     (c_vld),
		.num         (c_num),
		.den         (c_den),
		.side_out    (c_side)
	);

	sdz_div_pipe #(
		.NUM_W  (C_NUM_W),
		.DEN_W  (C_DEN_W),
		.Q_W    (C_Q_W),
		.SIDE_W ($bits(curve_t))
	) u_div_curve (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (c_vld),
		.num      (c_num),
		.den      (c_den),
		.side_in  (c_side),
		.out_vld  (r_vld),
		.quot     (r_q),
		.side_out (r_side)
	);

	sdz_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.flip_x  (cfg_q.flip_x),
		.flip_y  (cfg_q.flip_y),
		.in_vld  (r_vld),
		.q_in    (r_q),
		.side_in (r_side),
		.out_vld (s_vld),
		.x_quot  (sx_q),
		.y_quot  (sy_q),
		.x_side  (sx_side),
		.y_side  (sy_side)
	);

	always_comb begin
		x_fin = sx_side.ax.neg ? 16'(-sx_q) : sx_q;
		y_fin = sy_side.neg ? 16'(-sy_q) : sy_q;
		if (sx_side.dflt) begin
			x_fin = sx_side.ax.a;
			y_fin = sy_side.a;
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (s_vld) begin
			if (!out_vld_q || out_ready) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_ready) begin
				x_out_q <= x_skid_q;
				y_out_q <= y_skid_q;
			end
		end else if (s_vld) begin
			if (!out_vld_q || out_ready) begin
				x_out_q <= x_fin;
				y_out_q <= y_fin;
			end else begin
				x_skid_q <= x_fin;
				y_skid_q <= y_fin;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign x_shaped  = x_out_q;
	assign y_shaped  = y_out_q;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid stage occupied with empty output register");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_ready && s_vld))
		else $error("skid stage filled without a stalled output");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !out_ready |=> skid_vld_q && out_vld_q)
		else $error("skid transaction lost under back-pressure");

endmodule

// File: test/stick_deadzone_curve_shaper_core_tb.sv
// ----------------------------------------------------------------------------
// stick_deadzone_curve_shaper_core_tb
// Self-checking bench for the stick shaper: directed corner samples and random
// samples over several register settings, results predicted in the bench and
// compared in order, with bursty input and stalling output.
// ----------------------------------------------------------------------------
module stick_deadzone_curve_shaper_core_tb;
	import sdz_pkg::*;

	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
	} pair_t;

	// index past the last register, writes to it are ignored
	localparam logic [2:0] REG_NONE = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] x_raw = '0;
	logic signed [15:0] y_raw = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] x_shaped;
	logic signed [15:0] y_shaped;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_idx = '0;
	logic [15:0]        cfg_wdata = '0;

	cfg_t  shadow;
	pair_t shaped_q[$];
	int    mismatches = 0;
	int    stray = 0;
	bit    stall_on = 1'b1;
	int    burst_left = 0;

	stick_deadzone_curve_shaper_core uut (.*);

	always #4 clk = ~clk;

	function automatic logic [16:0] apply_curve(logic [16:0] u, logic [15:0] c);
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] q;
		if (u == 0 || u == Q16_ONE || c == LINEAR_CURVE) return u;
		den = 64'(c) * (64'h10000 - 64'(u)) + 64'd256 * 64'(u);
		if (den == 0) return Q16_ONE;
		num = 64'(u) << 24;
		q = (num + den / 2) / den;
		return (q > 64'h10000) ? Q16_ONE : q[16:0];
	endfunction

	function automatic logic [15:0] rescale(int a, int m, logic [16:0] r, logic flip);
		logic        neg;
		logic [63:0] lim;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] o;
		if (a == 0 || m == 0 || r == 0) return 16'h0;
		neg = (a < 0) ^ flip;
		lim = neg ? 64'd32768 : 64'd32767;
		num = 64'(a < 0 ? -a : a) * lim * 64'(r);
		den = 64'(m) << 16;
		o = (num + den / 2) / den;
		if (o > lim) o = lim;
		return neg ? 16'(-o) : o[15:0];
	endfunction

	function automatic pair_t shape_sample(logic [15:0] xr, logic [15:0] yr);
		pair_t       p;
		int          ax;
		int          ay;
		int          m;
		logic [16:0] r;
		logic [63:0] range;
		logic [63:0] u;
		if (shadow.x_center == 0 && shadow.y_center == 0 && shadow.dead_radius == 0 &&
				shadow.full_radius == FULL_RESET && shadow.curve_shape == LINEAR_CURVE &&
				!shadow.flip_x && !shadow.flip_y) begin
			p.x = xr;
			p.y = yr;
			return p;
		end
		ax = int'($signed(xr)) - int'(shadow.x_center);
		ay = int'($signed(yr)) - int'(shadow.y_center);
		ax = ax < -32768 ? -32768 : (ax > 32767 ? 32767 : ax);
		ay = ay < -32768 ? -32768 : (ay > 32767 ? 32767 : ay);
		m = (ax < 0 ? -ax : ax) > (ay < 0 ? -ay : ay) ? (ax < 0 ? -ax : ax) : (ay < 0 ? -ay : ay);
		if (m <= int'(shadow.dead_radius)) r = '0;
		else if (m >= int'(shadow.full_radius)) r = Q16_ONE;
		else begin
			range = 64'(shadow.full_radius) - 64'(shadow.dead_radius);
			u = ((64'(m) - 64'(shadow.dead_radius)) * 64'h10000 + range / 2) / range;
			r = apply_curve(u[16:0], shadow.curve_shape);
		end
		p.x = rescale(ax, m, r, shadow.flip_x);
		p.y = rescale(ay, m, r, shadow.flip_y);
		return p;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_X_CENTER:    shadow.x_center = val;
			REG_Y_CENTER:    shadow.y_center = val;
			REG_DEAD_RADIUS: shadow.dead_radius = val;
			REG_FULL_RADIUS: shadow.full_radius = val;
			REG_CURVE_SHAPE: shadow.curve_shape = val;
			REG_FLIP_X:      shadow.flip_x = val[0];
			REG_FLIP_Y:      shadow.flip_y = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(logic [15:0] xc, logic [15:0] yc, logic [15:0] dr,
			logic [15:0] fr, logic [15:0] cs, logic fx, logic fy);
		write_reg(REG_X_CENTER, xc);
		write_reg(REG_Y_CENTER, yc);
		write_reg(REG_DEAD_RADIUS, dr);
		write_reg(REG_FULL_RADIUS, fr);
		write_reg(REG_CURVE_SHAPE, cs);
		write_reg(REG_FLIP_X, {15'h0, fx});
		write_reg(REG_FLIP_Y, {15'h0, fy});
	endtask

	task automatic drain;
		while (shaped_q.size() != 0) @(negedge clk);
		repeat (70) @(negedge clk);
	endtask

	// one sample transaction, with a random gap between bursts
	task automatic send_sample(logic [15:0] xr, logic [15:0] yr);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		x_raw <= xr;
		y_raw <= yr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		shaped_q.push_back(shape_sample(xr, yr));
		@(negedge clk);
	endtask

	task automatic idle_input;
		in_valid <= 1'b0;
		burst_left = 0;
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_random(int n);
		repeat (n) send_sample(pick_value(), pick_value());
		idle_input();
		drain();
	endtask

	task automatic test_defaults_passthrough;
		send_sample(16'h8000, 16'h7fff);
		send_sample(16'h7fff, 16'h8000);
		send_sample(16'h0000, 16'h0000);
		send_sample(16'hffff, 16'h0001);
		run_random(150);
	endtask

	task automatic test_directed_corners;
		set_all(16'h0010, 16'hfff0, 16'd100, 16'd20000, 16'd512, 1'b1, 1'b0);
		send_sample(16'h8000, 16'h8000);
		send_sample(16'h7fff, 16'h7fff);
		send_sample(16'h0010, 16'hfff0);
		send_sample(16'h0074, 16'hfff0);
		send_sample(16'h0075, 16'h0000);
		send_sample(16'h4e30, 16'h1234);
		send_sample(16'h0000, 16'h8000);
		idle_input();
		drain();
		// empty band and zero curve factor
		set_all(16'h8000, 16'h7fff, 16'd5000, 16'd3000, 16'd0, 1'b0, 1'b1);
		send_sample(16'h7fff, 16'h8000);
		send_sample(16'h8000, 16'h7fff);
		send_sample(16'h9000, 16'h7000);
		idle_input();
		drain();
		set_all(16'h0000, 16'h0000, 16'd0, 16'd40000, 16'd0, 1'b1, 1'b1);
		send_sample(16'h0001, 16'h0000);
		send_sample(16'h8000, 16'h7fff);
		send_sample(16'h0000, 16'h0000);
		idle_input();
		drain();
		write_reg(REG_NONE, 16'hffff);
		send_sample(16'h1234, 16'h8765);
		idle_input();
		drain();
	endtask

	task automatic test_random_settings;
		int k;
		for (k = 0; k < 8; k++) begin
			case (k)
				0: set_all(16'h0, 16'h0, 16'd0, 16'd32768, 16'd65535, 1'b0, 1'b0);
				1: set_all(16'h7fff, 16'h8000, 16'd32768, 16'd32768, 16'd1, 1'b1, 1'b1);
				2: set_all(16'h0, 16'h0, 16'd0, 16'd0, 16'd256, 1'b0, 1'b1);
				default: set_all(16'(int'($urandom_range(0, 2000)) - 1000),
					16'(int'($urandom_range(0, 2000)) - 1000),
					16'($urandom_range(0, 8000)), 16'($urandom_range(8000, 32768)),
					16'($urandom_range(0, 2047)), 1'($urandom), 1'($urandom));
			endcase
			run_random(200);
		end
		set_all(16'h0, 16'h0, 16'd0, FULL_RESET, LINEAR_CURVE, 1'b0, 1'b0);
		run_random(150);
	endtask

	always @(negedge clk) begin
		if (stall_on) out_ready <= ($urandom_range(0, 3) != 0);
		else out_ready <= 1'b1;
	end

	// stall pattern switches on and off in long stretches
	always begin
		repeat ($urandom_range(50, 300)) @(negedge clk);
		stall_on = ~stall_on;
	end

	always @(posedge clk) begin
		pair_t e;
		if (arst_n && out_valid && out_ready) begin
			if (shaped_q.size() == 0) begin
				stray++;
				if (mismatches + stray <= 10) $display("unexpected transaction %h %h", x_shaped, y_shaped);
			end else begin
				e = shaped_q.pop_front();
				if (e.x !== x_shaped || e.y !== y_shaped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h %h got %h %h", e.x, e.y, x_shaped, y_shaped);
				end
			end
		end
	end

	initial begin
		shadow = '{default: '0};
		shadow.full_radius = FULL_RESET;
		shadow.curve_shape = LINEAR_CURVE;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_defaults_passthrough();
		test_directed_corners();
		test_random_settings();
		if (mismatches == 0 && stray == 0 && shaped_q.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
sv/sdz_pkg.sv
sv/sdz_div_pipe.sv
sv/sdz_front.sv
sv/sdz_curve.sv
sv/sdz_scale.sv
sv/stick_deadzone_curve_shaper_core.sv
test/stick_deadzone_curve_shaper_core_tb.sv
